/* rtl/tgc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the trajectory gesture classifier
// used by tgc_window and trajectory_gesture_classifier_unit
package tgc_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_DATA_W-1:0] span_t;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_THROW = 2'd1,
    GEST_PET   = 2'd2,
    GEST_WIPE  = 2'd3
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THROW_MIN_Y = 3'd0,
    CFG_THROW_MAX_X = 3'd1,
    CFG_PET_MIN_X   = 3'd2,
    CFG_PET_MAX_Y   = 3'd3,
    CFG_WIPE_MIN_Y  = 3'd4,
    CFG_WIPE_MIN_X  = 3'd5
  } cfg_idx_t;

  localparam span_t RST_THROW_MIN_Y = 12'd500;
  localparam span_t RST_THROW_MAX_X = 12'd150;
  localparam span_t RST_PET_MIN_X   = 12'd300;
  localparam span_t RST_PET_MAX_Y   = 12'd350;
  localparam span_t RST_WIPE_MIN_Y  = 12'd300;
  localparam span_t RST_WIPE_MIN_X  = 12'd300;

  // classification thresholds as seen by the datapath
  typedef struct packed {
    span_t throw_min_y;
    span_t throw_max_x;
    span_t pet_min_x;
    span_t pet_max_y;
    span_t wipe_min_y;
    span_t wipe_min_x;
  } cfg_t;

  // one result beat
  typedef struct packed {
    coord_t   track_x;
    coord_t   track_y;
    logic     verdict_valid;
    gesture_t gesture;
  } res_t;

endpackage

/* rtl/tgc_window.sv */
`timescale 1ns / 1ps
// tracked position, window extremes and span classification
// depends on tgc_pkg
module tgc_window #(
  parameter int WINDOW_POINTS = 15
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      object_found,
  input  tgc_pkg::coord_t           box_left,
  input  tgc_pkg::coord_t           box_top,
  input  tgc_pkg::coord_t           box_width,
  input  tgc_pkg::coord_t           box_height,
  input  tgc_pkg::cfg_t             cfg,
  output tgc_pkg::res_t             res
);
  import tgc_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_POINTS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  coord_t last_x_r, last_x_nxt;
  coord_t last_y_r, last_y_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  coord_t min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  coord_t min_y_r, min_y_nxt, max_y_r, max_y_nxt;

  logic [COORD_BITS:0] sum_x, sum_y;
  coord_t ctr_x, ctr_y;
  logic   full, start;
  span_t  span_x, span_y;
  gesture_t verdict;

  // box centre, saturating on carry out
  assign sum_x = {1'b0, box_left} + {2'b00, box_width[COORD_BITS-1:1]};
  assign sum_y = {1'b0, box_top}  + {2'b00, box_height[COORD_BITS-1:1]};
  assign ctr_x = sum_x[COORD_BITS] ? '1 : sum_x[COORD_BITS-1:0];
  assign ctr_y = sum_y[COORD_BITS] ? '1 : sum_y[COORD_BITS-1:0];

  assign last_x_nxt = object_found ? ctr_x : last_x_r;
  assign last_y_nxt = object_found ? ctr_y : last_y_r;

  assign full  = (cnt_r == CNT_FULL);
  assign start = full || (cnt_r == '0);

  always_comb begin
    if (start) begin
      min_x_nxt = last_x_nxt;
      max_x_nxt = last_x_nxt;
      min_y_nxt = last_y_nxt;
      max_y_nxt = last_y_nxt;
    end else begin
      min_x_nxt = (last_x_nxt < min_x_r) ? last_x_nxt : min_x_r;
      max_x_nxt = (last_x_nxt > max_x_r) ? last_x_nxt : max_x_r;
      min_y_nxt = (last_y_nxt < min_y_r) ? last_y_nxt : min_y_r;
      max_y_nxt = (last_y_nxt > max_y_r) ? last_y_nxt : max_y_r;
    end
  end

  assign cnt_nxt = full ? CNT_ONE : cnt_r + CNT_ONE;

  // spans of the window just completed, in priority order
  assign span_x = max_x_r - min_x_r;
  assign span_y = max_y_r - min_y_r;

  always_comb begin
    if (span_y > cfg.throw_min_y && span_x < cfg.throw_max_x) begin
      verdict = GEST_THROW;
    end else if (span_x > cfg.pet_min_x && span_y < cfg.pet_max_y) begin
      verdict = GEST_PET;
    end else if (span_y > cfg.wipe_min_y && span_x > cfg.wipe_min_x) begin
      verdict = GEST_WIPE;
    end else begin
      verdict = GEST_NONE;
    end
  end

  assign res.track_x       = last_x_nxt;
  assign res.track_y       = last_y_nxt;
  assign res.verdict_valid = full;
  assign res.gesture       = full ? verdict : GEST_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
      cnt_r    <= '0;
    end else if (step) begin
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // extremes are always written by the first point of a window
  always_ff @(posedge clk) begin
    if (step) begin
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("window point count beyond window size");

  a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && full |=> cnt_r == CNT_ONE)
    else $error("window did not restart after verdict");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cnt_r) && $stable(last_x_r) && $stable(last_y_r))
    else $error("tracking state moved without a beat");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (max_x_r >= min_x_r) && (max_y_r >= min_y_r))
    else $error("window extremes out of order");

endmodule

/* rtl/trajectory_gesture_classifier_unit.sv */
`timescale 1ns / 1ps
// top level: config registers, tracking datapath and two-entry result buffer
// depends on tgc_pkg and tgc_window
//
// Takes one bounding box beat per cycle while in_ready is high. Its result
// beat (tracked position, and a gesture verdict on the beat that follows every
// WINDOW_POINTS-point window) is presented from an output register; a
// second skid entry behind it lets a beat be accepted in the same cycle the
// output is stalled, and in_ready drops only while that skid entry holds a
// beat. Sustained rate is one beat per cycle while out_ready is held high,
// set by the per-beat update of the running window extremes. Config writes are
// accepted every cycle and must only be issued while the block is idle.
module trajectory_gesture_classifier_unit #(
  parameter int WINDOW_POINTS = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_object_found,
  input  logic [tgc_pkg::COORD_BITS-1:0]     in_box_left,
  input  logic [tgc_pkg::COORD_BITS-1:0]     in_box_top,
  input  logic [tgc_pkg::COORD_BITS-1:0]     in_box_width,
  input  logic [tgc_pkg::COORD_BITS-1:0]     in_box_height,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tgc_pkg::COORD_BITS-1:0]     out_track_x,
  output logic [tgc_pkg::COORD_BITS-1:0]     out_track_y,
  output logic                               out_verdict_valid,
  output logic [1:0]                         out_gesture,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tgc_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  res_t res_new;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic in_fire;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THROW_MIN_Y: cfg_nxt.throw_min_y = cfg_data;
        CFG_THROW_MAX_X: cfg_nxt.throw_max_x = cfg_data;
        CFG_PET_MIN_X:   cfg_nxt.pet_min_x   = cfg_data;
        CFG_PET_MAX_Y:   cfg_nxt.pet_max_y   = cfg_data;
        CFG_WIPE_MIN_Y:  cfg_nxt.wipe_min_y  = cfg_data;
        CFG_WIPE_MIN_X:  cfg_nxt.wipe_min_x  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throw_min_y <= RST_THROW_MIN_Y;
      cfg_r.throw_max_x <= RST_THROW_MAX_X;
      cfg_r.pet_min_x   <= RST_PET_MIN_X;
      cfg_r.pet_max_y   <= RST_PET_MAX_Y;
      cfg_r.wipe_min_y  <= RST_WIPE_MIN_Y;
      cfg_r.wipe_min_x  <= RST_WIPE_MIN_X;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  tgc_window #(
    .WINDOW_POINTS(WINDOW_POINTS)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .object_found(in_object_found),
    .box_left    (in_box_left),
    .box_top     (in_box_top),
    .box_width   (in_box_width),
    .box_height  (in_box_height),
    .cfg         (cfg_r),
    .res         (res_new)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : res_new;
    end else if (in_fire) begin
      skid_r <= res_new;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_track_x       = out_r.track_x;
  assign out_track_y       = out_r.track_y;
  assign out_verdict_valid = out_r.verdict_valid;
  assign out_gesture       = out_r.gesture;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a beat while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready && in_fire))
    else $error("skid entry filled without a stalled output");

endmodule

/* tb/tb_trajectory_gesture_classifier_unit.sv */
`timescale 1ns / 1ps
// self-checking bench for trajectory_gesture_classifier_unit: random window shapes around
// the span thresholds, several threshold settings, random source gaps and sink stalls
// depends on tgc_pkg and the unit's rtl
module tb_trajectory_gesture_classifier_unit;
  import tgc_pkg::*;

  localparam int WIN_PTS        = 15;
  localparam int NUM_REGS       = 6;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int NUM_PHASES     = 8;
  localparam int WINS_PER_PHASE = 9;
  localparam int DRAIN_CYCLES   = 8;
  localparam int BUSY_PCT       = 57;
  localparam int BOTH_PCT       = 28;

  typedef struct packed {
    logic   found;
    coord_t left;
    coord_t top;
    coord_t width;
    coord_t height;
  } box_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    span_t                data;
  } reg_write_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_object_found = 1'b0;
  coord_t               in_box_left = '0;
  coord_t               in_box_top = '0;
  coord_t               in_box_width = '0;
  coord_t               in_box_height = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  coord_t               out_track_x;
  coord_t               out_track_y;
  logic                 out_verdict_valid;
  logic [1:0]           out_gesture;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  span_t                cfg_data = '0;

  box_beat_t   box_q[$];
  reg_write_t  reg_q[$];
  res_t        track_q[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;

  // predictor state
  span_t    thr [NUM_REGS];
  coord_t   pos_x, pos_y;
  coord_t   win_min_x, win_max_x, win_min_y, win_max_y;
  logic [4:0] win_count;

  trajectory_gesture_classifier_unit #(.WINDOW_POINTS(WIN_PTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_object_found(in_object_found), .in_box_left(in_box_left),
    .in_box_top(in_box_top), .in_box_width(in_box_width),
    .in_box_height(in_box_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_track_x(out_track_x), .out_track_y(out_track_y),
    .out_verdict_valid(out_verdict_valid), .out_gesture(out_gesture),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic coord_t box_centre(coord_t start, coord_t size);
    logic [COORD_BITS:0] c;
    c = {1'b0, start} + {2'b00, size[COORD_BITS-1:1]};
    return (c > COORD_MAX) ? coord_t'(COORD_MAX) : c[COORD_BITS-1:0];
  endfunction

  function automatic res_t track_box(box_beat_t b);
    res_t  r;
    span_t sx, sy;
    if (b.found) begin
      pos_x = box_centre(b.left, b.width);
      pos_y = box_centre(b.top, b.height);
    end
    r.verdict_valid = 1'b0;
    r.gesture = GEST_NONE;
    if (win_count >= WIN_PTS) begin
      sx = win_max_x - win_min_x;
      sy = win_max_y - win_min_y;
      r.verdict_valid = 1'b1;
      if (sy > thr[CFG_THROW_MIN_Y] && sx < thr[CFG_THROW_MAX_X])
        r.gesture = GEST_THROW;
      else if (sx > thr[CFG_PET_MIN_X] && sy < thr[CFG_PET_MAX_Y])
        r.gesture = GEST_PET;
      else if (sy > thr[CFG_WIPE_MIN_Y] && sx > thr[CFG_WIPE_MIN_X])
        r.gesture = GEST_WIPE;
      win_count = '0;
    end
    if (win_count == 0) begin
      win_min_x = pos_x;
      win_max_x = pos_x;
      win_min_y = pos_y;
      win_max_y = pos_y;
    end else begin
      if (pos_x < win_min_x) win_min_x = pos_x;
      if (pos_x > win_max_x) win_max_x = pos_x;
      if (pos_y < win_min_y) win_min_y = pos_y;
      if (pos_y > win_max_y) win_max_y = pos_y;
    end
    win_count = win_count + 5'd1;
    r.track_x = pos_x;
    r.track_y = pos_y;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // driver: input beats from box_q, register writes from reg_q, random sink stalls
  always @(posedge clk) begin : driver
    box_beat_t  nb;
    reg_write_t wr;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (box_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nb = box_q.pop_front();
          in_valid        <= 1'b1;
          in_object_found <= nb.found;
          in_box_left     <= nb.left;
          in_box_top      <= nb.top;
          in_box_width    <= nb.width;
          in_box_height   <= nb.height;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_q.size() != 0) begin
          wr = reg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= wr.idx;
          cfg_data  <= wr.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: checks result beats, then predicts for the beat accepted at this edge
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      thr[CFG_THROW_MIN_Y] = RST_THROW_MIN_Y;
      thr[CFG_THROW_MAX_X] = RST_THROW_MAX_X;
      thr[CFG_PET_MIN_X]   = RST_PET_MIN_X;
      thr[CFG_PET_MAX_Y]   = RST_PET_MAX_Y;
      thr[CFG_WIPE_MIN_Y]  = RST_WIPE_MIN_Y;
      thr[CFG_WIPE_MIN_X]  = RST_WIPE_MIN_X;
      pos_x = '0;
      pos_y = '0;
      win_count = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (track_q.size() == 0) begin
          report_mismatch("unexpected result beat, track_x", out_track_x, 0);
        end else begin
          want = track_q.pop_front();
          if (out_track_x !== want.track_x)
            report_mismatch("track_x", out_track_x, want.track_x);
          if (out_track_y !== want.track_y)
            report_mismatch("track_y", out_track_y, want.track_y);
          if (out_verdict_valid !== want.verdict_valid)
            report_mismatch("verdict_valid", out_verdict_valid, want.verdict_valid);
          if (out_gesture !== want.gesture)
            report_mismatch("gesture", out_gesture, want.gesture);
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        thr[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        track_q.insert(track_q.size(), track_box({in_object_found, in_box_left,
                                                  in_box_top, in_box_width,
                                                  in_box_height}));
    end
  end

  task automatic queue_box(logic found, int unsigned l, int unsigned t,
                           int unsigned w, int unsigned h);
    box_q.insert(box_q.size(),
                 {found, coord_t'(l), coord_t'(t), coord_t'(w), coord_t'(h)});
  endtask

  task automatic queue_reg_write(int unsigned idx, int unsigned v);
    reg_q.insert(reg_q.size(), {CFG_IDX_W'(idx), span_t'(v)});
  endtask

  // one frame whose box centre lands on (x, y), with some lost and garbage frames
  task automatic queue_point(coord_t x, coord_t y);
    int unsigned r, hx, hy;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      queue_box(1'b0, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 10) begin
      queue_box(1'b1, $urandom, $urandom, $urandom, $urandom);
    end else begin
      hx = $urandom_range(0, (x < 31) ? x : 31);
      hy = $urandom_range(0, (y < 31) ? y : 31);
      queue_box(1'b1, x - hx, y - hy, 2 * hx + $urandom_range(0, 1),
                2 * hy + $urandom_range(0, 1));
    end
  endtask

  function automatic span_t span_above(span_t t);
    return (t == span_t'(COORD_MAX)) ? t : span_t'($urandom_range(t + 1, COORD_MAX));
  endfunction

  function automatic span_t span_below(span_t t);
    return (t == 0) ? t : span_t'($urandom_range(0, t - 1));
  endfunction

  function automatic span_t span_near_thr();
    int v;
    v = int'(thr[$urandom_range(0, NUM_REGS - 1)]) + int'($urandom_range(0, 2)) - 1;
    return span_t'((v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // a full window, aimed at a gesture shape in half the cases, extremes at random frames
  task automatic queue_window();
    span_t  sx, sy;
    coord_t x0, y0;
    coord_t px [WIN_PTS];
    coord_t py [WIN_PTS];
    int unsigned i, a, b;
    case ($urandom_range(0, 5))
      0: begin
        sx = span_below(thr[CFG_THROW_MAX_X]);
        sy = span_above(thr[CFG_THROW_MIN_Y]);
      end
      1: begin
        sx = span_above(thr[CFG_PET_MIN_X]);
        sy = span_below(thr[CFG_PET_MAX_Y]);
      end
      2: begin
        sx = span_above(thr[CFG_WIPE_MIN_X]);
        sy = span_above(thr[CFG_WIPE_MIN_Y]);
      end
      3: begin
        sx = span_t'($urandom_range(0, 63));
        sy = span_t'($urandom_range(0, 63));
      end
      4: begin
        sx = span_near_thr();
        sy = span_near_thr();
      end
      default: begin
        sx = span_t'($urandom);
        sy = span_t'($urandom);
      end
    endcase
    x0 = coord_t'($urandom_range(0, COORD_MAX - sx));
    y0 = coord_t'($urandom_range(0, COORD_MAX - sy));
    for (i = 0; i < WIN_PTS; i++) begin
      px[i] = x0 + coord_t'($urandom_range(0, sx));
      py[i] = y0 + coord_t'($urandom_range(0, sy));
    end
    a = $urandom_range(0, WIN_PTS - 1);
    b = (a + $urandom_range(1, WIN_PTS - 1)) % WIN_PTS;
    px[a] = x0;
    px[b] = x0 + sx;
    a = $urandom_range(0, WIN_PTS - 1);
    b = (a + $urandom_range(1, WIN_PTS - 1)) % WIN_PTS;
    py[a] = y0;
    py[b] = y0 + sy;
    for (i = 0; i < WIN_PTS; i++)
      queue_point(px[i], py[i]);
  endtask

  task automatic load_phase_config(int ph);
    int unsigned i;
    case (ph)
      1, 5: begin
        for (i = 0; i < NUM_REGS; i++) queue_reg_write(i, $urandom);
        // indexes past the register list must be dropped
        queue_reg_write(NUM_REGS, $urandom);
        queue_reg_write(NUM_REGS + 1, $urandom);
      end
      2: for (i = 0; i < NUM_REGS; i++) queue_reg_write(i, 0);
      3: for (i = 0; i < NUM_REGS; i++) queue_reg_write(i, COORD_MAX);
      4: for (i = 0; i < NUM_REGS; i++) queue_reg_write(i, $urandom_range(0, 700));
      6: begin
        queue_reg_write(CFG_THROW_MIN_Y, RST_THROW_MIN_Y);
        queue_reg_write(CFG_THROW_MAX_X, RST_THROW_MAX_X);
        queue_reg_write(CFG_PET_MIN_X, RST_PET_MIN_X);
        queue_reg_write(CFG_PET_MAX_Y, RST_PET_MAX_Y);
        queue_reg_write(CFG_WIPE_MIN_Y, RST_WIPE_MIN_Y);
        queue_reg_write(CFG_WIPE_MIN_X, RST_WIPE_MIN_X);
      end
      7: begin
        // loosest possible limits: every gesture is easy to hit
        queue_reg_write(CFG_THROW_MIN_Y, 0);
        queue_reg_write(CFG_THROW_MAX_X, COORD_MAX);
        queue_reg_write(CFG_PET_MIN_X, 0);
        queue_reg_write(CFG_PET_MAX_Y, COORD_MAX);
        queue_reg_write(CFG_WIPE_MIN_Y, 0);
        queue_reg_write(CFG_WIPE_MIN_X, 0);
      end
      default: ;
    endcase
  endtask

  // sampled on the falling edge so queue and valid state are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (box_q.size() != 0 || in_valid || track_q.size() != 0 ||
           reg_q.size() != 0 || cfg_valid);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int ph, w;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed window: zeros, saturation, held positions, bit patterns
    queue_box(1'b1, 0, 0, 0, 0);
    queue_box(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_box(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_box(1'b1, COORD_MAX, 0, 0, COORD_MAX);
    queue_box(1'b1, 0, COORD_MAX, COORD_MAX, 1);
    queue_box(1'b1, COORD_MAX - 1, COORD_MAX - 1, 2, 3);
    queue_box(1'b1, COORD_MAX - 1, 2048, 4, COORD_MAX);
    queue_box(1'b0, 0, 0, 0, 0);
    queue_box(1'b1, 1000, 1000, 1, 1);
    queue_box(1'b1, 12'hAAA, 12'h555, 12'h555, 12'hAAA);
    queue_box(1'b1, 12'h555, 12'hAAA, 12'hAAA, 12'h555);
    queue_box(1'b0, 12'hAAA, 12'h555, 12'h555, 12'hAAA);
    queue_box(1'b1, 12'h800, 12'h001, 12'hFFE, 12'h7FF);
    queue_box(1'b1, 12'h001, 12'h800, 12'h7FF, 12'hFFE);
    queue_box(1'b1, 12'h7FF, 12'h7FF, 12'h001, 12'h001);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_gap_pct = 0;        recv_stall_pct = 0;        end
        1: begin send_gap_pct = BUSY_PCT; recv_stall_pct = 0;        end
        2: begin send_gap_pct = 0;        recv_stall_pct = BUSY_PCT; end
        default: begin send_gap_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
      endcase
      load_phase_config(ph);
      do @(negedge clk); while (reg_q.size() != 0 || cfg_valid);
      @(negedge clk);
      for (w = 0; w < WINS_PER_PHASE; w++) queue_window();
    end
    // one more frame so the last window gets its verdict
    queue_point(coord_t'($urandom), coord_t'($urandom));
    wait_drained();
    if (track_q.size() != 0)
      report_mismatch("results still outstanding", track_q.size(), 0);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #500us;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/tgc_pkg.sv
rtl/tgc_window.sv
rtl/trajectory_gesture_classifier_unit.sv
tb/tb_trajectory_gesture_classifier_unit.sv
